FILE: rtl/ffba_pkg.sv
// shared types and constants of the first-fit block allocator
package ffba_pkg;

   localparam int unsigned ADDR_W     = 31;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned SIZE_ALIGN = 8;
   localparam int unsigned CSR_IDX_W  = 1;

   localparam logic [ADDR_W-1:0] BASE_RESET  = 31'd2048;
   localparam logic [ADDR_W-1:0] LIMIT_RESET = 31'd1610612736;

   localparam logic ACT_ALLOC   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_LIMIT     = 2'd2;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 1'd1;

   typedef struct packed {
      logic [WORD_W-1:0] start;
      logic [WORD_W-1:0] length;
   } entry_type;

   typedef struct packed {
      logic              action;
      logic [ADDR_W-1:0] request_size;
      logic [ADDR_W-1:0] release_address;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] address;
   } rsp_type;

endpackage

FILE: rtl/ffba_cell.sv
// one table cell: holds a block entry and takes its neighbor's entry on each shift
module ffba_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  ffba_pkg::entry_type entry_nxt,
   output ffba_pkg::entry_type entry
);

   ffba_pkg::entry_type entry_ff;
   ffba_pkg::entry_type entry_in;

   always_comb begin
      entry_in = shift_en ? entry_nxt : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: rtl/first_fit_block_allocator_core.sv
// first-fit block allocator: ring of table cells streamed past one head unit
// a scanned request passes through the scan and finish states, a refused allocate goes straight to finish
// one transfer at a time, the next accepted in the cycle after the result is queued
// the ring rotates once per scanned request, so the full MAX_BLOCKS cells pass the head
// reset: block count and used total cleared, base and limit to defaults, no clearing pass
// table cells are not reset, only entries below the block count are ever read
module first_fit_block_allocator_core #(
   parameter int unsigned MAX_BLOCKS = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ffba_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ffba_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [ffba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ffba_pkg::ADDR_W-1:0]        csr_wdata
);

   localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
   localparam int unsigned W     = ffba_pkg::WORD_W;
   localparam int unsigned AW    = ffba_pkg::ADDR_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   // control state
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [W-1:0]     total_ff, total_in;
   logic             done_ff, done_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]    base_ff, base_in;
   logic [AW-1:0]    limit_ff, limit_in;

   // per-request payload
   logic             action_ff, action_in;
   logic [W-1:0]     size_ff, size_in;
   logic [AW-1:0]    target_ff, target_in;
   logic [W-1:0]     amount_ff, amount_in;
   logic [1:0]       status_ff, status_in;
   logic [AW-1:0]    addr_ff, addr_in;
   ffba_pkg::rsp_type rsp_ff, rsp_in;

   // previous entry seen at the head, with its end formed without wrap
   ffba_pkg::entry_type prev_ff, prev_in;
   logic [W:0]          prev_end_ff, prev_end_in;

   // ring of cells
   ffba_pkg::entry_type cell_q   [MAX_BLOCKS];
   ffba_pkg::entry_type emit;
   logic                shift_en;

   // head decisions
   ffba_pkg::entry_type head, second;
   logic [W+1:0]        gap_diff;
   logic                in_table, gap_fit, place_gap, place_tail, match;
   logic [W-1:0]        tail_start;
   logic [W-1:0]        size_round;
   logic                last_idx, transfer_in, rsp_load;

   assign shift_en = (state_ff == ST_SCAN);
   assign head     = cell_q[0];
   assign second   = cell_q[1];

   // ring: cells shift toward the head, the head unit refills the far end
   for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
      ffba_pkg::entry_type nxt;
      if (k == MAX_BLOCKS - 1) begin : g_tail
         assign nxt = emit;
      end else begin : g_link
         assign nxt = cell_q[k+1];
      end
      ffba_cell u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .entry_nxt (nxt),
         .entry     (cell_q[k])
      );
   end

   // size rounded up to the alignment
   assign size_round = ({1'b0, req_data.request_size} + W'(ffba_pkg::SIZE_ALIGN - 1))
                       & ~W'(ffba_pkg::SIZE_ALIGN - 1);

   // gap between the previous block end and the block now at the head
   assign in_table   = (CNT_W'(idx_ff) < count_ff);
   assign gap_diff   = {2'b00, head.start} - {1'b0, prev_end_ff};
   assign gap_fit    = !gap_diff[W+1] && (gap_diff[W:0] >= {1'b0, size_ff});
   assign place_gap  = (action_ff == ffba_pkg::ACT_ALLOC) && !done_ff && (idx_ff != '0)
                       && in_table && gap_fit;
   assign place_tail = (action_ff == ffba_pkg::ACT_ALLOC) && !done_ff && !place_gap
                       && (CNT_W'(idx_ff) == count_ff);
   assign tail_start = (count_ff == '0) ? {1'b0, base_ff} : prev_end_ff[W-1:0];
   assign match      = (action_ff == ffba_pkg::ACT_RELEASE) && !done_ff && in_table
                       && (head.start == {1'b0, target_ff});
   assign last_idx   = (idx_ff == IDX_W'(MAX_BLOCKS - 1));

   // stream out: insert shifts later entries back one, removal pulls them forward one
   always_comb begin
      emit = head;
      if (action_ff == ffba_pkg::ACT_ALLOC) begin
         priority if (done_ff) begin
            emit = prev_ff;
         end else if (place_gap) begin
            emit.start  = prev_end_ff[W-1:0];
            emit.length = size_ff;
         end else if (place_tail) begin
            emit.start  = tail_start;
            emit.length = size_ff;
         end else begin
            emit = head;
         end
      end else begin
         emit = (done_ff || match) ? second : head;
      end
   end

   assign transfer_in = req_valid && !req_stall;
   assign rsp_load    = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      done_in      = done_ff;
      action_in    = action_ff;
      size_in      = size_ff;
      target_in    = target_ff;
      amount_in    = amount_ff;
      status_in    = status_ff;
      addr_in      = addr_ff;
      prev_in      = prev_ff;
      prev_end_in  = prev_end_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      base_in      = base_ff;
      limit_in     = limit_ff;

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            ffba_pkg::CSR_BASE:  base_in  = csr_wdata;
            ffba_pkg::CSR_LIMIT: limit_in = csr_wdata;
            default:             base_in  = base_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (transfer_in) begin
               action_in = req_data.action;
               size_in   = size_round;
               target_in = req_data.release_address;
               amount_in = size_round;
               status_in = ffba_pkg::STAT_OK;
               addr_in   = '0;
               idx_in    = '0;
               done_in   = 1'b0;
               // refusal order: full table first, then the limit
               if (req_data.action == ffba_pkg::ACT_ALLOC
                   && count_ff == CNT_W'(MAX_BLOCKS)) begin
                  status_in = ffba_pkg::STAT_FULL;
                  state_in  = ST_FINISH;
               end else if (req_data.action == ffba_pkg::ACT_ALLOC
                            && total_ff >= {1'b0, limit_ff}) begin
                  status_in = ffba_pkg::STAT_LIMIT;
                  state_in  = ST_FINISH;
               end else begin
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            prev_in     = head;
            prev_end_in = {1'b0, head.start} + {1'b0, head.length};
            idx_in      = idx_ff + 1'b1;
            if (place_gap || place_tail) begin
               done_in = 1'b1;
               addr_in = place_gap ? prev_end_ff[AW-1:0] : tail_start[AW-1:0];
            end
            if (match) begin
               done_in   = 1'b1;
               amount_in = head.length;
            end
            if (last_idx) begin
               state_in = ST_FINISH;
               // table size and used total change once the ring is back in order
               if (action_ff == ffba_pkg::ACT_ALLOC) begin
                  count_in = count_ff + 1'b1;
                  total_in = total_ff + amount_ff;
               end else if (done_ff || match) begin
                  count_in = count_ff - 1'b1;
                  total_in = total_ff - (match ? head.length : amount_ff);
               end else begin
                  status_in = ffba_pkg::STAT_NOT_FOUND;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_in.status  = status_ff;
               rsp_in.address = addr_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= ffba_pkg::BASE_RESET;
         limit_ff     <= ffba_pkg::LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      size_ff     <= size_in;
      target_ff   <= target_in;
      amount_ff   <= amount_in;
      status_ff   <= status_in;
      addr_ff     <= addr_in;
      prev_ff     <= prev_in;
      prev_end_ff <= prev_end_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
